// ===== design/ucdp_pkg.sv =====
package ucdp_pkg;

  localparam int unsigned BufferBytes = 256;
  localparam int unsigned PacketCap   = 64;

  localparam int unsigned IdxW   = 16;  // byte counter, saturates
  localparam int unsigned LimitW = 9;   // total length, capped at the buffer size
  localparam int unsigned NextW  = 10;  // start of the next descriptor

  localparam logic [LimitW-1:0] LIMIT_RESET = LimitW'(BufferBytes);
  localparam logic [IdxW-1:0]   IDX_MAX     = {IdxW{1'b1}};
  localparam logic [6:0]        MPS_CAP     = 7'(PacketCap);

  // Fixed byte positions in the set.
  localparam logic [IdxW-1:0] POS_LEN_LO = IdxW'(2);
  localparam logic [IdxW-1:0] POS_LEN_HI = IdxW'(3);
  localparam logic [IdxW-1:0] POS_CFG    = IdxW'(5);

  // Descriptor types and endpoint codes.
  localparam logic [7:0] DESC_INTERFACE = 8'h04;
  localparam logic [7:0] DESC_ENDPOINT  = 8'h05;
  localparam logic [7:0] IF_MIN_LEN     = 8'd6;
  localparam logic [7:0] EP_MIN_LEN     = 8'd7;
  localparam logic [7:0] EP_DIR_IN      = 8'h80;
  localparam logic [1:0] EP_XFER_INTR   = 2'b11;

  // Port speed ids.
  localparam logic [3:0] SPEED_FULL  = 4'd1;
  localparam logic [3:0] SPEED_LOW   = 4'd2;
  localparam logic [3:0] SPEED_RESET = SPEED_FULL;

  localparam logic [7:0] IV_RESET   = 8'd8;
  localparam logic [7:0] FS_EXP_MIN = 8'd3;
  localparam logic [7:0] FS_EXP_MAX = 8'd15;

  // Parse results as they stand after the current byte.
  typedef struct packed {
    logic [7:0]        config_id;
    logic [LimitW-1:0] total_length;
    logic [7:0]        interface_class;
    logic              ep_found;
    logic [3:0]        ep_num;
    logic [6:0]        ep_mps;
    logic [7:0]        ep_period;
  } parse_sum_t;

  // Smallest e >= 3 with 2^e >= iv * 8, clamped at 15.
  function automatic logic [7:0] fs_exponent(input logic [7:0] iv);
    logic [7:0] v;
    logic [3:0] bits;
    logic [7:0] e;
    v    = iv - 8'd1;
    bits = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (v[k]) begin
        bits = 4'(k + 1);
      end
    end
    if (iv <= 8'd1) begin
      e = FS_EXP_MIN;
    end else begin
      e = FS_EXP_MIN + {4'd0, bits};
    end
    if (e > FS_EXP_MAX) begin
      e = FS_EXP_MAX;
    end
    return e;
  endfunction

endpackage

// ===== design/ucdp_walker.sv =====
module ucdp_walker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output ucdp_pkg::parse_sum_t sum_o
);
  import ucdp_pkg::*;

  logic [IdxW-1:0]   byte_index_q, byte_index_d;
  logic [7:0]        len_low_q, len_low_d;
  logic [LimitW-1:0] limit_q, limit_d;
  logic [NextW-1:0]  next_start_q, next_start_d;
  logic [7:0]        cur_len_q, cur_len_d;
  logic [7:0]        cur_type_q, cur_type_d;
  logic              stopped_q, stopped_d;
  logic [7:0]        cfg_val_q, cfg_val_d;
  logic [7:0]        class_q, class_d;
  logic [3:0][7:0]   ep_bytes_q, ep_bytes_d;
  logic [7:0]        iv_pend_q, iv_pend_d;
  logic              ep_found_q, ep_found_d;
  logic [3:0]        ep_num_q, ep_num_d;
  logic [6:0]        ep_mps_q, ep_mps_d;
  logic [7:0]        ep_iv_q, ep_iv_d;

  logic [15:0]      total_raw;
  logic [NextW:0]   next_plus2;
  logic             stop_pre;
  logic             in_walk;
  logic             at_start;
  logic             zero_stop;
  logic             active;
  logic [NextW-1:0] i10;
  logic [NextW-1:0] desc_base;
  logic [NextW-1:0] rel;
  logic             commit;
  logic [15:0]      mps_raw;
  logic [7:0]       ep_addr;
  logic [7:0]       ep_attr;

  always_comb begin
    byte_index_d = byte_index_q;
    len_low_d    = len_low_q;
    limit_d      = limit_q;
    next_start_d = next_start_q;
    cur_len_d    = cur_len_q;
    cur_type_d   = cur_type_q;
    cfg_val_d    = cfg_val_q;
    class_d      = class_q;
    ep_bytes_d   = ep_bytes_q;
    iv_pend_d    = iv_pend_q;
    ep_found_d   = ep_found_q;
    ep_num_d     = ep_num_q;
    ep_mps_d     = ep_mps_q;
    ep_iv_d      = ep_iv_q;

    // Total length from bytes 2 and 3, capped at the buffer size.
    total_raw = {data_byte_i, len_low_q};
    if (byte_index_q == POS_LEN_LO) begin
      len_low_d = data_byte_i;
      limit_d   = {1'b0, data_byte_i};
    end else if (byte_index_q == POS_LEN_HI) begin
      limit_d = (total_raw > 16'(BufferBytes)) ? LIMIT_RESET : total_raw[LimitW-1:0];
    end
    if (byte_index_q == POS_CFG) begin
      cfg_val_d = data_byte_i;
    end

    // The walk stops once the next header no longer fits in the total.
    next_plus2 = {1'b0, next_start_q} + (NextW+1)'(2);
    stop_pre   = stopped_q || (next_plus2 > (NextW+1)'(limit_d));
    in_walk    = !stop_pre && (byte_index_q < IdxW'(limit_d));
    i10        = {1'b0, byte_index_q[LimitW-1:0]};
    at_start   = in_walk && (i10 == next_start_q);
    zero_stop  = at_start && (data_byte_i == 8'd0);
    stopped_d  = stop_pre || zero_stop;

    if (at_start && !zero_stop) begin
      cur_len_d    = data_byte_i;
      cur_type_d   = 8'd0;
      ep_bytes_d   = '0;
      iv_pend_d    = 8'd0;
      next_start_d = i10 + {2'b0, data_byte_i};
    end

    active    = in_walk && !zero_stop;
    desc_base = next_start_d - {2'b0, cur_len_d};
    rel       = i10 - desc_base;
    if (active) begin
      case (rel)
        NextW'(1): cur_type_d    = data_byte_i;
        NextW'(2): ep_bytes_d[0] = data_byte_i;
        NextW'(3): ep_bytes_d[1] = data_byte_i;
        NextW'(4): ep_bytes_d[2] = data_byte_i;
        NextW'(5): ep_bytes_d[3] = data_byte_i;
        NextW'(6): iv_pend_d     = data_byte_i;
        default: ;
      endcase
    end

    // A descriptor takes effect when its last byte is walked.
    commit  = active && ((i10 + NextW'(1)) == next_start_d);
    ep_addr = ep_bytes_d[0];
    ep_attr = ep_bytes_d[1];
    mps_raw = {ep_bytes_d[3], ep_bytes_d[2]};
    if (commit) begin
      if (cur_type_d == DESC_INTERFACE && cur_len_d >= IF_MIN_LEN && class_q == 8'd0) begin
        class_d = ep_bytes_d[3];
      end else if (cur_type_d == DESC_ENDPOINT && cur_len_d >= EP_MIN_LEN && !ep_found_q) begin
        if (((ep_addr & EP_DIR_IN) != 8'd0) && (ep_attr[1:0] == EP_XFER_INTR)) begin
          ep_found_d = 1'b1;
          ep_num_d   = ep_addr[3:0];
          ep_mps_d   = (mps_raw > 16'(PacketCap)) ? MPS_CAP : mps_raw[6:0];
          ep_iv_d    = iv_pend_d;
        end
      end
    end

    if (byte_index_q != IDX_MAX) begin
      byte_index_d = byte_index_q + IdxW'(1);
    end
  end

  assign sum_o = '{
    config_id:       cfg_val_d,
    total_length:    limit_d,
    interface_class: class_d,
    ep_found:        ep_found_d,
    ep_num:          ep_num_d,
    ep_mps:          ep_mps_d,
    ep_period:       ep_iv_d
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      len_low_q    <= '0;
      limit_q      <= LIMIT_RESET;
      next_start_q <= '0;
      cur_len_q    <= '0;
      cur_type_q   <= '0;
      stopped_q    <= 1'b0;
      cfg_val_q    <= '0;
      class_q      <= '0;
      ep_bytes_q   <= '0;
      iv_pend_q    <= '0;
      ep_found_q   <= 1'b0;
      ep_num_q     <= '0;
      ep_mps_q     <= '0;
      ep_iv_q      <= IV_RESET;
    end else if (step_i && last_byte_i) begin
      // The set is complete: rearm for the next one.
      byte_index_q <= '0;
      len_low_q    <= '0;
      limit_q      <= LIMIT_RESET;
      next_start_q <= '0;
      cur_len_q    <= '0;
      cur_type_q   <= '0;
      stopped_q    <= 1'b0;
      cfg_val_q    <= '0;
      class_q      <= '0;
      ep_bytes_q   <= '0;
      iv_pend_q    <= '0;
      ep_found_q   <= 1'b0;
      ep_num_q     <= '0;
      ep_mps_q     <= '0;
      ep_iv_q      <= IV_RESET;
    end else if (step_i) begin
      byte_index_q <= byte_index_d;
      len_low_q    <= len_low_d;
      limit_q      <= limit_d;
      next_start_q <= next_start_d;
      cur_len_q    <= cur_len_d;
      cur_type_q   <= cur_type_d;
      stopped_q    <= stopped_d;
      cfg_val_q    <= cfg_val_d;
      class_q      <= class_d;
      ep_bytes_q   <= ep_bytes_d;
      iv_pend_q    <= iv_pend_d;
      ep_found_q   <= ep_found_d;
      ep_num_q     <= ep_num_d;
      ep_mps_q     <= ep_mps_d;
      ep_iv_q      <= ep_iv_d;
    end
  end

endmodule

// ===== design/ucdp_result.sv =====
module ucdp_result (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  ucdp_pkg::parse_sum_t         sum_i,
  input  logic [3:0]                   port_speed_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [7:0]                   config_id_o,
  output logic [ucdp_pkg::LimitW-1:0]  total_length_o,
  output logic [7:0]                   interface_class_o,
  output logic                         endpoint_found_o,
  output logic [3:0]                   endpoint_number_o,
  output logic [4:0]                   context_index_o,
  output logic [6:0]                   max_packet_o,
  output logic [7:0]                   service_interval_o
);
  import ucdp_pkg::*;

  logic              valid_q, valid_d;
  logic [7:0]        cfg_q;
  logic [LimitW-1:0] total_q;
  logic [7:0]        class_q;
  logic              found_q;
  logic [3:0]        num_q;
  logic [4:0]        ctx_q;
  logic [6:0]        mps_q;
  logic [7:0]        svc_q;

  logic [7:0] svc_d;

  always_comb begin
    if (port_speed_i == SPEED_FULL || port_speed_i == SPEED_LOW) begin
      svc_d = fs_exponent(sum_i.ep_period);
    end else if (sum_i.ep_period == 8'd0) begin
      svc_d = 8'd0;
    end else begin
      svc_d = sum_i.ep_period - 8'd1;
    end

    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cfg_q   <= sum_i.config_id;
      total_q <= sum_i.total_length;
      class_q <= sum_i.interface_class;
      found_q <= sum_i.ep_found;
      num_q   <= sum_i.ep_found ? sum_i.ep_num : 4'd0;
      ctx_q   <= sum_i.ep_found ? {sum_i.ep_num, 1'b1} : 5'd0;
      mps_q   <= sum_i.ep_found ? sum_i.ep_mps : 7'd0;
      svc_q   <= sum_i.ep_found ? svc_d : 8'd0;
    end
  end

  assign out_valid_o        = valid_q;
  assign config_id_o        = cfg_q;
  assign total_length_o     = total_q;
  assign interface_class_o  = class_q;
  assign endpoint_found_o   = found_q;
  assign endpoint_number_o  = num_q;
  assign context_index_o    = ctx_q;
  assign max_packet_o       = mps_q;
  assign service_interval_o = svc_q;

endmodule

// ===== design/usb_config_descriptor_parser.sv =====
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   data_byte_i, last_byte_i
// out       output     out_valid_o/out_ready_i config_id_o .. service_interval_o
// cfg       input      cfg_we_i                cfg_wdata_i (port speed)
//
// One byte is accepted per cycle unless the input stalls. A byte waits in the input
// register, where the descriptor walk updates the parse state; a set's result is loaded
// into the output register as its last byte leaves, if that register is free.
// Reset clears all control and parse state; port speed resets to full speed.
// Only a last byte waits on a full output register, and the input stalls behind it.
module usb_config_descriptor_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  config_id_o,
  output logic [ucdp_pkg::LimitW-1:0] total_length_o,
  output logic [7:0]                  interface_class_o,
  output logic                        endpoint_found_o,
  output logic [3:0]                  endpoint_number_o,
  output logic [4:0]                  context_index_o,
  output logic [6:0]                  max_packet_o,
  output logic [7:0]                  service_interval_o,
  input  logic                        cfg_we_i,
  input  logic [3:0]                  cfg_wdata_i
);
  import ucdp_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic [3:0] speed_q;
  logic       s1_go;
  logic       in_take;
  parse_sum_t sum;

  // A last byte advances only when the output register can take its result.
  assign s1_go      = s1_valid_q && (!s1_last_q || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    if (in_take) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      speed_q    <= SPEED_RESET;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (cfg_we_i) begin
        speed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  ucdp_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_go),
    .data_byte_i (s1_data_q),
    .last_byte_i (s1_last_q),
    .sum_o       (sum)
  );

  ucdp_result u_result (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (s1_go && s1_last_q),
    .sum_i              (sum),
    .port_speed_i       (speed_q),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .config_id_o        (config_id_o),
    .total_length_o     (total_length_o),
    .interface_class_o  (interface_class_o),
    .endpoint_found_o   (endpoint_found_o),
    .endpoint_number_o  (endpoint_number_o),
    .context_index_o    (context_index_o),
    .max_packet_o       (max_packet_o),
    .service_interval_o (service_interval_o)
  );

endmodule
